@@ rtl/core/shpmf_pkg.sv @@
// Package for the sample histogram block: fixed widths, limits and word layouts.
// No dependencies; used by sample_histogram_pmf_unit.
package shpmf_pkg;

	localparam int SAMPLE_BITS = 12;
	localparam int COUNT_BITS  = 11;
	localparam int SPAN        = 1 << SAMPLE_BITS;

	localparam logic [SAMPLE_BITS-1:0] VALUE_TOP   = SAMPLE_BITS'(SPAN - 1);
	localparam logic [COUNT_BITS-1:0]  MAX_SAMPLES = COUNT_BITS'(1024);

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [COUNT_BITS-1:0]  count_t;

	typedef struct packed {
		logic    op;
		sample_t sample;
		sample_t bin_offset;
	} req_word_t;

	typedef struct packed {
		count_t  bin_count;
		sample_t min_value;
		sample_t max_value;
		count_t  peak_count;
		count_t  samples_held;
		logic    dropped;
	} rsp_word_t;

endpackage

@@ rtl/core/shpmf_stream_if.sv @@
// Valid/ready stream interface carrying one word of a given packed type.
// Depends on nothing; the word type is set by the instantiating level.
interface shpmf_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/sample_histogram_pmf_unit.sv @@
// Histogram of converter samples with running minimum, maximum and peak count.
// Depends on shpmf_pkg and shpmf_stream_if.

// Each word on req either adds a sample (op 0) or reads the bin at bin_offset above
// the current minimum (op 1); every word gives exactly one word on rsp with the
// statistics as they stand after it. Counts live in a 4096 x 11 simple dual-port
// memory with a registered read. After reset the block sweeps all 4096 entries to
// zero, one entry a cycle, with req.ready low. After that each word first reads its
// count entry, then updates it and writes it back, and no new word is taken until
// that write-back is done. The response sits in an output register; the next word
// is taken no earlier than the cycle in which that response leaves on rsp, so a
// stalled rsp holds req.ready low.
// Adds beyond 1024 samples are ignored and flagged with dropped.
module sample_histogram_pmf_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	shpmf_stream_if.sink          req,
	shpmf_stream_if.source        rsp
);
	import shpmf_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_WAIT  = 2'd2;

	logic [1:0] state_q;
	sample_t    clear_addr_q;

	// statistics
	sample_t lowest_q;
	sample_t highest_q;
	count_t  largest_q;
	count_t  total_q;

	// word in flight
	logic    op_q;
	sample_t addr_q;
	logic    oob_q;
	logic    drop_q;

	// count memory
	count_t  mem [SPAN];
	count_t  rd_data_q;
	sample_t rd_addr;
	logic    we;
	sample_t wr_addr;
	count_t  wr_data;

	logic      out_valid_q;
	rsp_word_t out_word_q;

	logic                 accept;
	logic [SAMPLE_BITS:0] rel_sum;
	count_t               inc;
	logic                 do_add;
	sample_t              lowest_nx;
	sample_t              highest_nx;
	count_t               largest_nx;
	count_t               total_nx;

	assign req.ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;

	assign rel_sum = {1'b0, lowest_q} + {1'b0, req.data.bin_offset};
	assign rd_addr = (req.data.op == OP_READ) ? rel_sum[SAMPLE_BITS-1:0] : req.data.sample;

	assign inc    = rd_data_q + COUNT_BITS'(1);
	assign do_add = (state_q == ST_WAIT) && (op_q == OP_ADD) && !drop_q;

	always_comb begin
		lowest_nx  = lowest_q;
		highest_nx = highest_q;
		largest_nx = largest_q;
		total_nx   = total_q;
		if (do_add) begin
			if (addr_q < lowest_q) begin
				lowest_nx = addr_q;
			end
			if (addr_q > highest_q) begin
				highest_nx = addr_q;
			end
			if (inc > largest_q) begin
				largest_nx = inc;
			end
			total_nx = total_q + COUNT_BITS'(1);
		end
	end

	always_comb begin
		we      = 1'b0;
		wr_addr = addr_q;
		wr_data = inc;
		if (state_q == ST_CLEAR) begin
			we      = 1'b1;
			wr_addr = clear_addr_q;
			wr_data = '0;
		end else if (do_add) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clear_addr_q <= '0;
			lowest_q     <= VALUE_TOP;
			highest_q    <= '0;
			largest_q    <= '0;
			total_q      <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clear_addr_q <= clear_addr_q + SAMPLE_BITS'(1);
					if (clear_addr_q == VALUE_TOP) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			lowest_q  <= lowest_nx;
			highest_q <= highest_nx;
			largest_q <= largest_nx;
			total_q   <= total_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= req.data.op;
			addr_q <= rd_addr;
			oob_q  <= rel_sum[SAMPLE_BITS];
			drop_q <= (req.data.op == OP_ADD) && (total_q == MAX_SAMPLES);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_WAIT) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT) begin
			out_word_q.bin_count    <= (op_q == OP_READ && !oob_q) ? rd_data_q : '0;
			out_word_q.min_value    <= lowest_nx;
			out_word_q.max_value    <= highest_nx;
			out_word_q.peak_count   <= largest_nx;
			out_word_q.samples_held <= total_nx;
			out_word_q.dropped      <= (op_q == OP_ADD) && drop_q;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_word_q;

endmodule
